[sv/lesf_pkg.sv]
// Package for the largest empty square finder.
// Holds widths, limits, register indexes and the structs passed between the stages.
// No dependencies.
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CHAR_W   = 8;
  localparam int DIM_W    = 11;
  localparam int SIZE_W   = 11;
  localparam int IDX_W    = 2;

  localparam logic [SIZE_W-1:0] SIZE_SAT  = {SIZE_W{1'b1}};
  localparam logic [DIM_W-1:0]  COLS_LIM  = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0]  ROWS_LIM  = DIM_W'(MAX_ROWS);
  localparam logic [CHAR_W-1:0] EMPTY_RST = CHAR_W'(46);

  localparam logic [IDX_W-1:0] CFG_EMPTY_CHAR = 2'd0;
  localparam logic [IDX_W-1:0] CFG_NUM_COLS   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_NUM_ROWS   = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             done;
    logic             empty;
  } stage_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } rd_req_t;

endpackage

[sv/lesf_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lesf_front.sv]
// Front stage: configuration registers, raster counters, input handshake and line-buffer read.
// Depends on lesf_pkg.
module lesf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lesf_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [lesf_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lesf_pkg::CHAR_W-1:0]  cell_char_i,
  input  logic                         s1_go_i,
  output lesf_pkg::stage_t             s1_o,
  output lesf_pkg::rd_req_t            rd_o
);

  logic [lesf_pkg::CHAR_W-1:0] empty_char_q;
  logic [lesf_pkg::DIM_W-1:0]  num_cols_q;
  logic [lesf_pkg::DIM_W-1:0]  num_rows_q;
  logic [lesf_pkg::DIM_W-1:0]  cols_eff;
  logic [lesf_pkg::DIM_W-1:0]  rows_eff;
  logic [lesf_pkg::COL_W-1:0]  col_q, col_d;
  logic [lesf_pkg::ROW_W-1:0]  row_q, row_d;
  logic                        last_col, last_row, done, acc;
  lesf_pkg::stage_t            s1_q, s1_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q <= lesf_pkg::EMPTY_RST;
      num_cols_q   <= lesf_pkg::COLS_LIM;
      num_rows_q   <= lesf_pkg::ROWS_LIM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lesf_pkg::CFG_EMPTY_CHAR: empty_char_q <= cfg_data_i[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::CFG_NUM_COLS:   num_cols_q   <= cfg_data_i;
        lesf_pkg::CFG_NUM_ROWS:   num_rows_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_cols_q == '0) begin
      cols_eff = lesf_pkg::DIM_W'(1);
    end else if (num_cols_q > lesf_pkg::COLS_LIM) begin
      cols_eff = lesf_pkg::COLS_LIM;
    end else begin
      cols_eff = num_cols_q;
    end
    if (num_rows_q == '0) begin
      rows_eff = lesf_pkg::DIM_W'(1);
    end else if (num_rows_q > lesf_pkg::ROWS_LIM) begin
      rows_eff = lesf_pkg::ROWS_LIM;
    end else begin
      rows_eff = num_rows_q;
    end
  end

  assign last_col   = (lesf_pkg::DIM_W'(col_q) + lesf_pkg::DIM_W'(1)) >= cols_eff;
  assign last_row   = (lesf_pkg::DIM_W'(row_q) + lesf_pkg::DIM_W'(1)) >= rows_eff;
  assign done       = last_col && last_row;
  assign in_stall_o = s1_q.valid && !s1_go_i;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (done) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + lesf_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + lesf_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (acc) begin
      s1_d.valid    = 1'b1;
      s1_d.row      = row_q;
      s1_d.col      = col_q;
      s1_d.last_col = last_col;
      s1_d.done     = done;
      s1_d.empty    = (cell_char_i == empty_char_q);
    end else if (s1_go_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      s1_q  <= s1_d;
    end
  end

  assign s1_o    = s1_q;
  assign rd_o.en   = acc;
  assign rd_o.addr = col_q;

endmodule

[sv/lesf_cell.sv]
// Compute stage: square size from the line buffer, left and diagonal neighbors,
// best-square tracking, line-buffer write-back and the output register. Depends on lesf_pkg.
module lesf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lesf_pkg::stage_t              s1_i,
  input  lesf_pkg::rd_req_t             rd_i,
  input  logic [lesf_pkg::SIZE_W-1:0]   rd_data_i,
  output logic                          s1_go_o,
  output logic                          wr_en_o,
  output logic [lesf_pkg::COL_W-1:0]    wr_addr_o,
  output logic [lesf_pkg::SIZE_W-1:0]   wr_data_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lesf_pkg::SIZE_W-1:0]   cell_size_o,
  output logic [lesf_pkg::SIZE_W-1:0]   best_size_o,
  output logic [lesf_pkg::ROW_W-1:0]    best_row_o,
  output logic [lesf_pkg::COL_W-1:0]    best_col_o,
  output logic                          map_done_o
);

  logic [lesf_pkg::SIZE_W-1:0] left_q, diag_q, fwd_q;
  logic                        fwd_hit_q;
  logic [lesf_pkg::SIZE_W-1:0] best_size_q;
  logic [lesf_pkg::ROW_W-1:0]  best_row_q;
  logic [lesf_pkg::COL_W-1:0]  best_col_q;
  logic                        out_valid_q;
  logic [lesf_pkg::SIZE_W-1:0] cell_size_q, out_best_size_q;
  logic [lesf_pkg::ROW_W-1:0]  out_best_row_q;
  logic [lesf_pkg::COL_W-1:0]  out_best_col_q;
  logic                        map_done_q;
  logic [lesf_pkg::SIZE_W-1:0] up, up_raw, m, size;
  logic [lesf_pkg::SIZE_W-1:0] nbest_size;
  logic [lesf_pkg::ROW_W-1:0]  nbest_row;
  logic [lesf_pkg::COL_W-1:0]  nbest_col;
  logic                        go;

  assign go      = s1_i.valid && (!out_valid_q || !out_stall_i);
  assign s1_go_o = go;

  assign up_raw = fwd_hit_q ? fwd_q : rd_data_i;
  assign up     = (s1_i.row == '0) ? '0 : up_raw;

  always_comb begin
    m = up;
    if (left_q < m) begin
      m = left_q;
    end
    if (diag_q < m) begin
      m = diag_q;
    end
    if (!s1_i.empty) begin
      size = '0;
    end else if (s1_i.row == '0 || s1_i.col == '0) begin
      size = lesf_pkg::SIZE_W'(1);
    end else if (m == lesf_pkg::SIZE_SAT) begin
      size = lesf_pkg::SIZE_SAT;
    end else begin
      size = m + lesf_pkg::SIZE_W'(1);
    end
    nbest_size = best_size_q;
    nbest_row  = best_row_q;
    nbest_col  = best_col_q;
    if (size > best_size_q) begin
      nbest_size = size;
      nbest_row  = s1_i.row;
      nbest_col  = s1_i.col;
    end
  end

  assign wr_en_o   = go;
  assign wr_addr_o = s1_i.col;
  assign wr_data_o = size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (go) begin
        out_valid_q <= 1'b1;
        if (s1_i.done) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
        end else begin
          best_size_q <= nbest_size;
          best_row_q  <= nbest_row;
          best_col_q  <= nbest_col;
        end
        if (s1_i.done || s1_i.last_col) begin
          left_q <= '0;
          diag_q <= '0;
        end else begin
          left_q <= size;
          diag_q <= up;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (rd_i.en) begin
        fwd_hit_q <= go && (rd_i.addr == s1_i.col);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      fwd_q <= size;
    end
    if (go) begin
      cell_size_q     <= size;
      out_best_size_q <= nbest_size;
      out_best_row_q  <= nbest_row;
      out_best_col_q  <= nbest_col;
      map_done_q      <= s1_i.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_size_o = cell_size_q;
  assign best_size_o = out_best_size_q;
  assign best_row_o  = out_best_row_q;
  assign best_col_o  = out_best_col_q;
  assign map_done_o  = map_done_q;

endmodule

[sv/largest_empty_square_finder_top.sv]
// Top level of the largest empty square finder.
// Depends on lesf_pkg, lesf_ram, lesf_front and lesf_cell.
//
// Usage: map cells enter one item per cycle unless stalled on the input channel
// (in_valid_i, in_stall_o, cell_char_i) in row-major order. For every cell one
// result item leaves on the output channel (out_valid_o, out_stall_i and the
// result fields): the size of the largest empty square ending at that cell, the
// best square so far with its bottom-right row and column, and map_done_o on the
// last cell of the map, after which the block starts the next map from row 0.
// Cells pass the front and output registers. Throughput is one cell per cycle
// unless stalled, set by the single read and single write per cycle of the
// line-buffer RAM that holds the previous row's sizes; a cell reading the entry
// written by the cell just before it is forwarded around the RAM.
// Configuration (empty_char, num_cols, num_rows) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no item is in flight.
// Reset clears the counters and the best square and restores the default
// configuration; the line buffer is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item and one more
// cell can sit in the compute stage; beyond that in_stall_o is raised.
module largest_empty_square_finder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lesf_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [lesf_pkg::DIM_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lesf_pkg::CHAR_W-1:0]   cell_char_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lesf_pkg::SIZE_W-1:0]   cell_size_o,
  output logic [lesf_pkg::SIZE_W-1:0]   best_size_o,
  output logic [lesf_pkg::ROW_W-1:0]    best_row_o,
  output logic [lesf_pkg::COL_W-1:0]    best_col_o,
  output logic                          map_done_o
);

  lesf_pkg::stage_t            s1;
  lesf_pkg::rd_req_t           rd;
  logic                        s1_go;
  logic                        wr_en;
  logic [lesf_pkg::COL_W-1:0]  wr_addr;
  logic [lesf_pkg::SIZE_W-1:0] wr_data;
  logic [lesf_pkg::SIZE_W-1:0] rd_data;

  lesf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cell_char_i (cell_char_i),
    .s1_go_i     (s1_go),
    .s1_o        (s1),
    .rd_o        (rd)
  );

  lesf_ram #(
    .WIDTH (lesf_pkg::SIZE_W),
    .DEPTH (lesf_pkg::MAX_COLS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rd_data)
  );

  lesf_cell u_cell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .rd_i        (rd),
    .rd_data_i   (rd_data),
    .s1_go_o     (s1_go),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_size_o (cell_size_o),
    .best_size_o (best_size_o),
    .best_row_o  (best_row_o),
    .best_col_o  (best_col_o),
    .map_done_o  (map_done_o)
  );

endmodule

[tb/lesf_checker.sv]
// Checker for the largest empty square finder: watches the register port and both channels,
// predicts every result item from its own model of the map scan, and counts mismatches.
// Depends on lesf_pkg.
module lesf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lesf_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [lesf_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [lesf_pkg::CHAR_W-1:0] cell_char_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [lesf_pkg::SIZE_W-1:0] cell_size_i,
  input  logic [lesf_pkg::SIZE_W-1:0] best_size_i,
  input  logic [lesf_pkg::ROW_W-1:0]  best_row_i,
  input  logic [lesf_pkg::COL_W-1:0]  best_col_i,
  input  logic                        map_done_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          cells_left_o,
  output logic [lesf_pkg::ROW_W-1:0]  cur_row_o
);
  import lesf_pkg::*;

  typedef struct packed {
    logic [SIZE_W-1:0] cell_size;
    logic [SIZE_W-1:0] best_size;
    logic [ROW_W-1:0]  best_row;
    logic [COL_W-1:0]  best_col;
    logic              map_done;
  } square_t;

  logic [CHAR_W-1:0] empty_code;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [SIZE_W-1:0] line_sizes [MAX_COLS];
  logic [SIZE_W-1:0] left_run;
  logic [SIZE_W-1:0] diag_run;
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic [SIZE_W-1:0] top_size;
  logic [ROW_W-1:0]  top_row;
  logic [COL_W-1:0]  top_col;

  square_t predicted_squares[$];
  square_t seen_square;
  square_t due_square;
  square_t next_square;
  int      mismatches;

  function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int lim);
    if (raw == '0) return 1;
    if (int'(raw) > lim) return lim;
    return int'(raw);
  endfunction

  function automatic int map_cells_left();
    int cols;
    int rows;
    int in_row;
    cols = eff_dim(width_reg, MAX_COLS);
    rows = eff_dim(height_reg, MAX_ROWS);
    in_row = (int'(col_pos) + 1 >= cols) ? 1 : cols - int'(col_pos);
    if (int'(row_pos) + 1 >= rows) return in_row;
    return in_row + (rows - int'(row_pos) - 1) * cols;
  endfunction

  task automatic restart_scan();
    left_run = '0;
    diag_run = '0;
    row_pos  = '0;
    col_pos  = '0;
    top_size = '0;
    top_row  = '0;
    top_col  = '0;
  endtask

  task automatic predict_square(input logic [CHAR_W-1:0] ch, output square_t res);
    int                cols;
    int                rows;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] least;
    logic [SIZE_W-1:0] sz;
    logic              last_col;
    logic              done;
    cols = eff_dim(width_reg, MAX_COLS);
    rows = eff_dim(height_reg, MAX_ROWS);
    up = (row_pos != '0) ? line_sizes[col_pos] : '0;
    if (ch != empty_code) begin
      sz = '0;
    end else if (row_pos == '0 || col_pos == '0) begin
      sz = SIZE_W'(1);
    end else begin
      least = up;
      if (left_run < least) least = left_run;
      if (diag_run < least) least = diag_run;
      sz = (least == SIZE_SAT) ? SIZE_SAT : least + SIZE_W'(1);
    end
    if (sz > top_size) begin
      top_size = sz;
      top_row  = row_pos;
      top_col  = col_pos;
    end
    line_sizes[col_pos] = sz;
    last_col = (int'(col_pos) + 1 >= cols);
    done = last_col && (int'(row_pos) + 1 >= rows);
    res.cell_size = sz;
    res.best_size = top_size;
    res.best_row  = top_row;
    res.best_col  = top_col;
    res.map_done  = done;
    if (done) begin
      restart_scan();
    end else if (last_col) begin
      col_pos  = '0;
      row_pos  = row_pos + ROW_W'(1);
      left_run = '0;
      diag_run = '0;
    end else begin
      col_pos  = col_pos + COL_W'(1);
      left_run = sz;
      diag_run = up;
    end
  endtask

  task automatic report_failure(input string what, input square_t want, input square_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected size %0d best %0d at (%0d,%0d) done %0b", $realtime, what,
               want.cell_size, want.best_size, want.best_row, want.best_col, want.map_done);
      $display("%0t: %s: got      size %0d best %0d at (%0d,%0d) done %0b", $realtime, what,
               got.cell_size, got.best_size, got.best_row, got.best_col, got.map_done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_code = EMPTY_RST;
      width_reg  = COLS_LIM;
      height_reg = ROWS_LIM;
      foreach (line_sizes[i]) line_sizes[i] = '0;
      restart_scan();
      predicted_squares.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      cells_left_o <= 0;
      cur_row_o    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EMPTY_CHAR: empty_code = cfg_data_i[CHAR_W-1:0];
          CFG_NUM_COLS:   width_reg  = cfg_data_i;
          CFG_NUM_ROWS:   height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen_square.cell_size = cell_size_i;
        seen_square.best_size = best_size_i;
        seen_square.best_row  = best_row_i;
        seen_square.best_col  = best_col_i;
        seen_square.map_done  = map_done_i;
        if (predicted_squares.size() == 0) begin
          report_failure("unexpected item", '0, seen_square);
        end else begin
          due_square = predicted_squares.pop_front();
          if (seen_square.cell_size !== due_square.cell_size ||
              seen_square.best_size !== due_square.best_size ||
              seen_square.best_row  !== due_square.best_row  ||
              seen_square.best_col  !== due_square.best_col  ||
              seen_square.map_done  !== due_square.map_done) begin
            report_failure("mismatch", due_square, seen_square);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_square(cell_char_i, next_square);
        predicted_squares.push_back(next_square);
      end
      fail_count_o <= mismatches;
      pending_o    <= predicted_squares.size();
      cells_left_o <= map_cells_left();
      cur_row_o    <= row_pos;
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the largest empty square finder: drives clock, reset, register writes and
// map cells with random idling on both channels, and gives the verdict.
// Depends on lesf_pkg, largest_empty_square_finder_top and lesf_checker.
module tb_top;
  import lesf_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED   = 2'd3;
  localparam int               RANDOM_CELLS = 880;
  localparam int               HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_idx = '0;
  logic [DIM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic [CHAR_W-1:0] cell_char = '0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [SIZE_W-1:0] cell_size;
  logic [SIZE_W-1:0] best_size;
  logic [ROW_W-1:0]  best_row;
  logic [COL_W-1:0]  best_col;
  logic              map_done;

  int               fail_count;
  int               pending;
  int               cells_left;
  logic [ROW_W-1:0] cur_row;

  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  int               hold_req = 0;
  int               hold_ack = 0;
  int               hold_left = 0;
  int               cells_sent = 0;
  int               reg_writes = 0;
  logic [CHAR_W-1:0] cur_empty = CHAR_W'(46);
  logic [DIM_W-1:0]  cur_cols = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  largest_empty_square_finder_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cell_char_i (cell_char),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cell_size_o (cell_size),
    .best_size_o (best_size),
    .best_row_o  (best_row),
    .best_col_o  (best_col),
    .map_done_o  (map_done)
  );

  lesf_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cell_char_i  (cell_char),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .cell_size_i  (cell_size),
    .best_size_i  (best_size),
    .best_row_i   (best_row),
    .best_col_i   (best_col),
    .map_done_i   (map_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .cells_left_o (cells_left),
    .cur_row_o    (cur_row)
  );

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_char <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_cell(input int empty_pct);
    return ($urandom_range(99) < empty_pct) ? cur_empty : CHAR_W'($urandom);
  endfunction

  task automatic send_cells(input int count);
    repeat (count) send_cell(pick_cell(75));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_empty(input logic [CHAR_W-1:0] code);
    cur_empty = code;
    write_reg(CFG_EMPTY_CHAR, {3'($urandom_range(7)), code});
  endtask

  task automatic change_mid_map();
    case ($urandom_range(2))
      0: set_empty(CHAR_W'($urandom));
      1: write_reg(CFG_NUM_ROWS, DIM_W'($urandom_range(8)));
      default: begin
        // The width may only grow while the first row is still open.
        if (cur_row == '0) cur_cols = DIM_W'($urandom_range(40));
        else cur_cols = DIM_W'($urandom_range(int'(cur_cols)));
        write_reg(CFG_NUM_COLS, cur_cols);
      end
    endcase
  endtask

  task automatic random_map();
    int split;
    wait_idle();
    if ($urandom_range(3) == 0) set_empty(CHAR_W'($urandom));
    case ($urandom_range(9))
      0:       cur_cols = '0;
      1:       cur_cols = DIM_W'($urandom_range(40, 13));
      default: cur_cols = DIM_W'($urandom_range(12, 1));
    endcase
    write_reg(CFG_NUM_COLS, cur_cols);
    write_reg(CFG_NUM_ROWS, ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(8, 1)));
    if (cells_left > 2 && $urandom_range(3) == 0) begin
      split = $urandom_range(cells_left - 1, 1);
      send_cells(split);
      wait_idle();
      change_mid_map();
    end
    send_cells(cells_left);
  endtask

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int random_base;
    int ph;
    int idle_tx [4] = '{0, 76, 0, 18};
    int idle_rx [4] = '{0, 0, 76, 18};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers, then the map is cut down while its first row is open.
    send_cell(CHAR_W'(46));
    send_cell(CHAR_W'(111));
    send_cell(CHAR_W'(46));
    wait_idle();
    cur_cols = DIM_W'(4);
    write_reg(CFG_NUM_COLS, cur_cols);
    write_reg(CFG_NUM_ROWS, DIM_W'(3));
    send_cell(CHAR_W'(46));
    repeat (6) send_cell(CHAR_W'(46));
    send_cell(CHAR_W'(0));
    send_cell(CHAR_W'(46));

    // Zero sizes act as a single cell.
    wait_idle();
    write_reg(CFG_NUM_COLS, '0);
    write_reg(CFG_NUM_ROWS, '0);
    send_cell(CHAR_W'(46));
    send_cell(CHAR_W'(255));

    wait_idle();
    write_reg(CFG_EMPTY_CHAR, DIM_W'(11'h7FF));
    cur_empty = CHAR_W'(255);
    write_reg(CFG_NUM_COLS, DIM_W'(3));
    write_reg(CFG_NUM_ROWS, DIM_W'(2));
    repeat (5) send_cell(CHAR_W'(255));
    send_cell(CHAR_W'(0));
    wait_idle();
    write_reg(CFG_UNUSED, DIM_W'($urandom));

    // Oversized width, then oversized height; each map is cut short by a smaller register.
    set_empty('0);
    write_reg(CFG_NUM_COLS, DIM_W'(11'h7FF));
    write_reg(CFG_NUM_ROWS, '0);
    repeat (40) send_cell(pick_cell(90));
    wait_idle();
    write_reg(CFG_NUM_COLS, '0);
    repeat (cells_left) send_cell(pick_cell(90));
    wait_idle();
    write_reg(CFG_NUM_ROWS, DIM_W'(11'h7FF));
    repeat (60) send_cell(pick_cell(50));
    wait_idle();
    write_reg(CFG_NUM_ROWS, '0);
    repeat (cells_left) send_cell(pick_cell(50));

    // The receiver holds off while cells keep coming, so the block backs up.
    wait_idle();
    set_empty(CHAR_W'(46));
    cur_cols = DIM_W'(8);
    write_reg(CFG_NUM_COLS, cur_cols);
    write_reg(CFG_NUM_ROWS, DIM_W'(6));
    hold_req <= hold_req + 1;
    send_cells(cells_left);

    random_base = cells_sent;
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      tx_idle_pct = idle_tx[ph];
      rx_stall_pct <= idle_rx[ph];
      while (cells_sent < random_base + RANDOM_CELLS * (ph + 1) / 4) random_map();
    end

    wait_idle();
    repeat (5) @(posedge clk);
    $display("Run covered %0d cells and %0d register writes: small directed maps, zero and",
             cells_sent, reg_writes);
    $display("oversized registers, mid-map register changes, a long hold-off and %0s",
             "four idling phases.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
sv/lesf_pkg.sv
sv/lesf_ram.sv
sv/lesf_front.sv
sv/lesf_cell.sv
sv/largest_empty_square_finder_top.sv
tb/lesf_checker.sv
tb/tb_top.sv
